// ----- rtl/bwfs_pkg.sv -----
// shared types and constants of the b-spline warp field sampler
// no dependencies

package bwfs_pkg;

   localparam int DEF_GRID_COLS = 6;
   localparam int DEF_GRID_ROWS = 4;

   localparam int NODE_IDX_W  = 5;
   localparam int MAX_NODES   = 1 << NODE_IDX_W;
   localparam int BASE_W      = 6;
   localparam int FRAC_W      = 16;
   localparam int DISP_W      = 16;
   localparam int COORD_W     = 17;
   localparam int QUEUE_DEPTH = 4;
   localparam int OUT_DEPTH   = 16;
   localparam int WEIGHT_W    = 20;

   localparam logic [COORD_W-1:0] COORD_ONE = COORD_W'(65536);
   // ceil(2^26 / 6), exact floor division by six for the weight numerators
   localparam logic [23:0] RECIP_SIX = 24'd11184811;

   typedef enum logic {
      KIND_WRITE  = 1'b0,
      KIND_SAMPLE = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type                     kind;
      logic [NODE_IDX_W-1:0]        node_index;
      logic signed [DISP_W-1:0]     node_dx;
      logic signed [DISP_W-1:0]     node_dy;
      logic [BASE_W-1:0]            base_x;
      logic [BASE_W-1:0]            base_y;
      logic [FRAC_W-1:0]            frac_x;
      logic [FRAC_W-1:0]            frac_y;
   } item_type;

endpackage

// ----- rtl/bspline_warp_field_sampler.sv -----
// Uniform cubic B-spline warp field sampler. Takes one item per clock
// cycle, writes and samples alike, with no stall as long as results are
// popped; a sample's result reaches the result queue via the back-end
// pipeline. Node writes take effect in order with samples: a sample sees
// every write pushed before it. The node store starts at zero after reset
// without a clearing pass (per-node valid flags). Up to 16 results wait in
// the result queue; the issue stage holds samples back while 16 are owed.
// depends on bwfs_pkg, bwfs_front, bwfs_back

module bspline_warp_field_sampler import bwfs_pkg::*; #(
   parameter int GRID_COLS = DEF_GRID_COLS,
   parameter int GRID_ROWS = DEF_GRID_ROWS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  logic                     req_kind,
   input  logic [NODE_IDX_W-1:0]    req_node_index,
   input  logic signed [DISP_W-1:0] req_node_dx,
   input  logic signed [DISP_W-1:0] req_node_dy,
   input  logic [COORD_W-1:0]       req_coord_u,
   input  logic [COORD_W-1:0]       req_coord_v,
   output logic                     empty,
   input  logic                     pop,
   output logic signed [DISP_W-1:0] rsp_disp_x,
   output logic signed [DISP_W-1:0] rsp_disp_y
);

   localparam int OAW = $clog2(OUT_DEPTH);

   logic                     q_valid, q_pop, credit_ok;
   item_type                 q_head;
   logic                     res_valid;
   logic signed [DISP_W-1:0] res_x, res_y;

   logic [2*DISP_W-1:0] out_ff [OUT_DEPTH];
   logic [OAW-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [OAW:0]        count_ff, count_in;
   logic [OAW:0]        owed_ff, owed_in;
   logic                issue_sample, rsp_xfer;

   bwfs_front #(
      .GRID_COLS (GRID_COLS),
      .GRID_ROWS (GRID_ROWS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_kind       (req_kind),
      .req_node_index (req_node_index),
      .req_node_dx    (req_node_dx),
      .req_node_dy    (req_node_dy),
      .req_coord_u    (req_coord_u),
      .req_coord_v    (req_coord_v),
      .q_valid        (q_valid),
      .q_head         (q_head),
      .q_pop          (q_pop)
   );

   bwfs_back #(
      .GRID_COLS (GRID_COLS),
      .GRID_ROWS (GRID_ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .credit_ok (credit_ok),
      .q_pop     (q_pop),
      .res_valid (res_valid),
      .res_x     (res_x),
      .res_y     (res_y)
   );

   assign empty        = (count_ff == '0);
   assign rsp_xfer     = pop && !empty;
   assign issue_sample = q_pop && q_head.kind == KIND_SAMPLE;
   assign credit_ok    = (owed_ff < (OAW+1)'(OUT_DEPTH));
   assign rsp_disp_x   = out_ff[rd_ptr_ff][DISP_W-1:0];
   assign rsp_disp_y   = out_ff[rd_ptr_ff][2*DISP_W-1:DISP_W];

   always_comb begin
      count_in = count_ff + (OAW+1)'(res_valid) - (OAW+1)'(rsp_xfer);
      owed_in  = owed_ff + (OAW+1)'(issue_sample) - (OAW+1)'(rsp_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         owed_ff   <= '0;
      end else begin
         if (res_valid) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (rsp_xfer) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
         owed_ff  <= owed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         out_ff[wr_ptr_ff] <= {res_y, res_x};
      end
   end

   // owed results never exceed the result queue
   a_owed_bound: assert property (@(posedge clock) disable iff (reset)
      owed_ff <= (OAW+1)'(OUT_DEPTH))
      else $error("owed results exceed result queue");

   // a finished result always finds room
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (count_ff != (OAW+1)'(OUT_DEPTH) || rsp_xfer))
      else $error("result queue overflow");

   // queued results are a subset of owed results
   a_count_owed: assert property (@(posedge clock) disable iff (reset)
      count_ff <= owed_ff)
      else $error("result queue holds more than owed");

   // no sample is issued without credit
   a_credit: assert property (@(posedge clock) disable iff (reset)
      issue_sample |-> credit_ok)
      else $error("sample issued without credit");

endmodule

// ----- rtl/bwfs_ram.sv -----
// generic single write port ram with registered read
// no dependencies

module bwfs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 24
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/bwfs_front.sv -----
// front end: accepts items, clamps and scales sample coordinates, queues them
// depends on bwfs_pkg

module bwfs_front import bwfs_pkg::*; #(
   parameter int GRID_COLS = DEF_GRID_COLS,
   parameter int GRID_ROWS = DEF_GRID_ROWS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  logic                        req_kind,
   input  logic [NODE_IDX_W-1:0]       req_node_index,
   input  logic signed [DISP_W-1:0]    req_node_dx,
   input  logic signed [DISP_W-1:0]    req_node_dy,
   input  logic [COORD_W-1:0]          req_coord_u,
   input  logic [COORD_W-1:0]          req_coord_v,
   output logic                        q_valid,
   output item_type                    q_head,
   input  logic                        q_pop
);

   localparam int QAW = $clog2(QUEUE_DEPTH);
   localparam int GW  = FRAC_W + BASE_W;

   item_type           queue_ff [QUEUE_DEPTH];
   logic [QAW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]       count_ff, count_in;
   logic [COORD_W-1:0] u_clamp, v_clamp;
   logic [GW-1:0]      gx, gy;
   item_type           entry;
   logic               do_push;

   always_comb begin
      u_clamp = (req_coord_u > COORD_ONE) ? COORD_ONE : req_coord_u;
      v_clamp = (req_coord_v > COORD_ONE) ? COORD_ONE : req_coord_v;
      gx = GW'(u_clamp) * GW'(GRID_COLS - 1);
      gy = GW'(v_clamp) * GW'(GRID_ROWS - 1);
      entry.kind       = kind_type'(req_kind);
      entry.node_index = req_node_index;
      entry.node_dx    = req_node_dx;
      entry.node_dy    = req_node_dy;
      entry.base_x     = gx[GW-1:FRAC_W];
      entry.base_y     = gy[GW-1:FRAC_W];
      entry.frac_x     = gx[FRAC_W-1:0];
      entry.frac_y     = gy[FRAC_W-1:0];
   end

   assign full    = (count_ff == (QAW+1)'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign q_valid = (count_ff != '0);
   assign q_head  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QAW+1)'(do_push) - (QAW+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

// ----- rtl/bwfs_back.sv -----
// back end: node store, b-spline weights and the 4x4 weighted sum pipeline
// depends on bwfs_pkg and bwfs_ram

module bwfs_back import bwfs_pkg::*; #(
   parameter int GRID_COLS = DEF_GRID_COLS,
   parameter int GRID_ROWS = DEF_GRID_ROWS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  item_type                 q_head,
   input  logic                     credit_ok,
   output logic                     q_pop,
   output logic                     res_valid,
   output logic signed [DISP_W-1:0] res_x,
   output logic signed [DISP_W-1:0] res_y
);

   localparam int NODE_COUNT = GRID_COLS * GRID_ROWS;
   localparam int NODE_DEPTH = (NODE_COUNT < MAX_NODES) ? NODE_COUNT : MAX_NODES;
   localparam int AW         = $clog2(NODE_DEPTH);
   localparam int IW         = $clog2(NODE_COUNT);

   // stage 1: addresses
   logic           p1_valid_ff;
   item_type       p1_item_ff;
   logic [IW-1:0]  p1_addr_ff [16];
   logic [IW-1:0]  addr_in [16];
   // stage 2: squares
   logic           p2_valid_ff;
   item_type       p2_item_ff;
   logic [IW-1:0]  p2_addr_ff [16];
   logic [31:0]    p2_t2_ff [2];
   logic [33:0]    p2_om2_ff [2];
   logic [16:0]    p2_om_ff [2];
   // stage 3: cubes, node store access
   logic           p3_valid_ff;
   item_type       p3_item_ff;
   logic [IW-1:0]  p3_addr_ff [16];
   logic [31:0]    p3_t2_ff [2];
   logic [47:0]    p3_t3_ff [2];
   logic [50:0]    p3_om3_ff [2];
   // stage 4: weight numerators
   logic           p4_valid_ff;
   logic [22:0]    p4_num_ff [2][4];
   logic [22:0]    num_in [2][4];
   logic           rd_ok_ff [16];
   logic [31:0]    ram_q [16];
   // stage 5: weights and node data
   logic                      p5_valid_ff;
   logic [WEIGHT_W-1:0]       p5_w_ff [2][4];
   logic signed [DISP_W-1:0]  p5_dx_ff [16];
   logic signed [DISP_W-1:0]  p5_dy_ff [16];
   // stage 6: tap products
   logic                      p6_valid_ff;
   logic signed [36:0]        p6_px_ff [16];
   logic signed [36:0]        p6_py_ff [16];
   logic [WEIGHT_W-1:0]       p6_wy_ff [4];
   // stage 7: row sums
   logic                      p7_valid_ff;
   logic signed [38:0]        p7_rx_ff [4];
   logic signed [38:0]        p7_ry_ff [4];
   logic [WEIGHT_W-1:0]       p7_wy_ff [4];
   // stage 8: split row products
   logic                      p8_valid_ff;
   logic signed [37:0]        p8_lx_ff [4], p8_ly_ff [4];
   logic signed [43:0]        p8_hx_ff [4], p8_hy_ff [4];
   // stage 9: row products
   logic                      p9_valid_ff;
   logic signed [59:0]        p9_x_ff [4], p9_y_ff [4];
   // stage 10: result
   logic                      p10_valid_ff;
   logic signed [DISP_W-1:0]  p10_x_ff, p10_x_in;
   logic signed [DISP_W-1:0]  p10_y_ff, p10_y_in;

   logic                  node_ok_ff [NODE_DEPTH];
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;

   assign q_pop = q_valid && (q_head.kind == KIND_WRITE || credit_ok);

   always_comb begin
      int col, row;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            col = int'(q_head.base_x) + c - 1;
            row = int'(q_head.base_y) + r - 1;
            if (col < 0) col = 0;
            if (col > GRID_COLS - 1) col = GRID_COLS - 1;
            if (row < 0) row = 0;
            if (row > GRID_ROWS - 1) row = GRID_ROWS - 1;
            addr_in[r*4+c] = IW'(row * GRID_COLS + col);
         end
      end
   end

   always_comb begin
      logic [52:0] w6 [4];
      logic [52:0] t, t2, t3;
      for (int a = 0; a < 2; a++) begin
         t  = 53'(p3_item_ff.frac_x);
         if (a == 1) t = 53'(p3_item_ff.frac_y);
         t2 = 53'(p3_t2_ff[a]);
         t3 = 53'(p3_t3_ff[a]);
         w6[0] = 53'(p3_om3_ff[a]);
         w6[1] = (53'(1) << 50) + 53'(3) * t3 - 53'(6) * (t2 << 16);
         w6[2] = (53'(1) << 48) + 53'(3) * (t << 32) + 53'(3) * (t2 << 16)
                 - 53'(3) * t3;
         w6[3] = t3;
         for (int i = 0; i < 4; i++) begin
            num_in[a][i] = 23'((w6[i] + (53'(3) << 28)) >> 28);
         end
      end
   end

   always_comb begin
      logic signed [63:0] tx, ty;
      tx = (64'sd1 <<< 39);
      ty = (64'sd1 <<< 39);
      for (int r = 0; r < 4; r++) begin
         tx = tx + 64'(p9_x_ff[r]);
         ty = ty + 64'(p9_y_ff[r]);
      end
      tx = tx >>> 40;
      ty = ty >>> 40;
      if (tx > 64'sd32767) p10_x_in = 16'sh7fff;
      else if (tx < -64'sd32768) p10_x_in = 16'sh8000;
      else p10_x_in = DISP_W'(tx);
      if (ty > 64'sd32767) p10_y_in = 16'sh7fff;
      else if (ty < -64'sd32768) p10_y_in = 16'sh8000;
      else p10_y_in = DISP_W'(ty);
   end

   assign wr_en   = p3_valid_ff && p3_item_ff.kind == KIND_WRITE
                    && int'(p3_item_ff.node_index) < NODE_COUNT;
   assign wr_addr = p3_item_ff.node_index[AW-1:0];

   for (genvar k = 0; k < 16; k++) begin : g_tap
      bwfs_ram #(
         .WIDTH (2 * DISP_W),
         .DEPTH (NODE_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_addr),
         .wr_data ({p3_item_ff.node_dy, p3_item_ff.node_dx}),
         .rd_addr (p3_addr_ff[k][AW-1:0]),
         .rd_data (ram_q[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         p4_valid_ff  <= 1'b0;
         p5_valid_ff  <= 1'b0;
         p6_valid_ff  <= 1'b0;
         p7_valid_ff  <= 1'b0;
         p8_valid_ff  <= 1'b0;
         p9_valid_ff  <= 1'b0;
         p10_valid_ff <= 1'b0;
         for (int i = 0; i < NODE_DEPTH; i++) begin
            node_ok_ff[i] <= 1'b0;
         end
      end else begin
         p1_valid_ff  <= q_pop;
         p2_valid_ff  <= p1_valid_ff;
         p3_valid_ff  <= p2_valid_ff;
         p4_valid_ff  <= p3_valid_ff && p3_item_ff.kind == KIND_SAMPLE;
         p5_valid_ff  <= p4_valid_ff;
         p6_valid_ff  <= p5_valid_ff;
         p7_valid_ff  <= p6_valid_ff;
         p8_valid_ff  <= p7_valid_ff;
         p9_valid_ff  <= p8_valid_ff;
         p10_valid_ff <= p9_valid_ff;
         if (wr_en) begin
            node_ok_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      logic signed [20:0] wx, wy;
      logic signed [16:0] lo;
      logic signed [38:0] sx, sy;
      p1_item_ff <= q_head;
      p2_item_ff <= p1_item_ff;
      p3_item_ff <= p2_item_ff;
      for (int k = 0; k < 16; k++) begin
         p1_addr_ff[k] <= addr_in[k];
         p2_addr_ff[k] <= p1_addr_ff[k];
         p3_addr_ff[k] <= p2_addr_ff[k];
         rd_ok_ff[k]   <= (int'(p3_addr_ff[k]) < NODE_DEPTH)
                          && node_ok_ff[p3_addr_ff[k][AW-1:0]];
         p5_dx_ff[k]   <= rd_ok_ff[k] ? ram_q[k][DISP_W-1:0] : '0;
         p5_dy_ff[k]   <= rd_ok_ff[k] ? ram_q[k][2*DISP_W-1:DISP_W] : '0;
      end
      p2_t2_ff[0]  <= 32'(p1_item_ff.frac_x) * 32'(p1_item_ff.frac_x);
      p2_t2_ff[1]  <= 32'(p1_item_ff.frac_y) * 32'(p1_item_ff.frac_y);
      p2_om2_ff[0] <= 34'(17'h10000 - 17'(p1_item_ff.frac_x))
                      * 34'(17'h10000 - 17'(p1_item_ff.frac_x));
      p2_om2_ff[1] <= 34'(17'h10000 - 17'(p1_item_ff.frac_y))
                      * 34'(17'h10000 - 17'(p1_item_ff.frac_y));
      p2_om_ff[0]  <= 17'h10000 - 17'(p1_item_ff.frac_x);
      p2_om_ff[1]  <= 17'h10000 - 17'(p1_item_ff.frac_y);
      p3_t3_ff[0]  <= 48'(p2_t2_ff[0]) * 48'(p2_item_ff.frac_x);
      p3_t3_ff[1]  <= 48'(p2_t2_ff[1]) * 48'(p2_item_ff.frac_y);
      for (int a = 0; a < 2; a++) begin
         p3_t2_ff[a]  <= p2_t2_ff[a];
         p3_om3_ff[a] <= 51'(p2_om2_ff[a]) * 51'(p2_om_ff[a]);
         for (int i = 0; i < 4; i++) begin
            p4_num_ff[a][i] <= num_in[a][i];
            p5_w_ff[a][i]   <= WEIGHT_W'((47'(p4_num_ff[a][i]) * 47'(RECIP_SIX)) >> 26);
         end
      end
      for (int r = 0; r < 4; r++) begin
         p6_wy_ff[r] <= p5_w_ff[1][r];
         p7_wy_ff[r] <= p6_wy_ff[r];
         for (int c = 0; c < 4; c++) begin
            wx = $signed({1'b0, p5_w_ff[0][c]});
            p6_px_ff[r*4+c] <= 37'(p5_dx_ff[r*4+c]) * 37'(wx);
            p6_py_ff[r*4+c] <= 37'(p5_dy_ff[r*4+c]) * 37'(wx);
         end
         sx = 39'(p6_px_ff[r*4]) + 39'(p6_px_ff[r*4+1])
              + 39'(p6_px_ff[r*4+2]) + 39'(p6_px_ff[r*4+3]);
         sy = 39'(p6_py_ff[r*4]) + 39'(p6_py_ff[r*4+1])
              + 39'(p6_py_ff[r*4+2]) + 39'(p6_py_ff[r*4+3]);
         p7_rx_ff[r] <= sx;
         p7_ry_ff[r] <= sy;
         wy = $signed({1'b0, p7_wy_ff[r]});
         lo = $signed({1'b0, p7_rx_ff[r][15:0]});
         p8_lx_ff[r] <= 38'(lo) * 38'(wy);
         lo = $signed({1'b0, p7_ry_ff[r][15:0]});
         p8_ly_ff[r] <= 38'(lo) * 38'(wy);
         p8_hx_ff[r] <= 44'($signed(p7_rx_ff[r][38:16])) * 44'(wy);
         p8_hy_ff[r] <= 44'($signed(p7_ry_ff[r][38:16])) * 44'(wy);
         p9_x_ff[r]  <= (60'(p8_hx_ff[r]) <<< 16) + 60'(p8_lx_ff[r]);
         p9_y_ff[r]  <= (60'(p8_hy_ff[r]) <<< 16) + 60'(p8_ly_ff[r]);
      end
      p10_x_ff <= p10_x_in;
      p10_y_ff <= p10_y_in;
   end

   assign res_valid = p10_valid_ff;
   assign res_x     = p10_x_ff;
   assign res_y     = p10_y_ff;

endmodule

// ----- tb/tb_top.sv -----
// testbench for the b-spline warp field sampler: drives node writes and samples,
// predicts each sample's displacement and checks the popped results in order
// depends on bwfs_pkg and bspline_warp_field_sampler

class warp_scoreboard;
   int unsigned errors;
   logic signed [15:0] grid_x [24];
   logic signed [15:0] grid_y [24];
   logic signed [15:0] owed_x [$];
   logic signed [15:0] owed_y [$];

   function new();
      errors = 0;
      foreach (grid_x[i]) begin
         grid_x[i] = 0;
         grid_y[i] = 0;
      end
   endfunction

   function void axis_weights(logic [15:0] frac, output longint w[4]);
      longint s;
      longint t;
      longint om;
      longint w6[4];
      s = 65536;
      t = frac;
      om = s - t;
      w6[0] = om * om * om;
      w6[1] = 4 * s * s * s + 3 * t * t * t - 6 * t * t * s;
      w6[2] = s * s * s + 3 * t * s * s + 3 * t * t * s - 3 * t * t * t;
      w6[3] = t * t * t;
      for (int i = 0; i < 4; i++) w[i] = (w6[i] + (longint'(3) << 28)) / (longint'(6) << 28);
   endfunction

   function logic signed [15:0] blend(bit use_y, int bx, int by, longint wx[4], longint wy[4]);
      longint total;
      longint rowsum;
      longint r;
      int yy;
      int xx;
      total = 0;
      for (int ri = 0; ri < 4; ri++) begin
         yy = by + ri - 1;
         if (yy < 0) yy = 0;
         if (yy > 3) yy = 3;
         rowsum = 0;
         for (int ci = 0; ci < 4; ci++) begin
            xx = bx + ci - 1;
            if (xx < 0) xx = 0;
            if (xx > 5) xx = 5;
            rowsum += longint'(use_y ? grid_y[yy*6+xx] : grid_x[yy*6+xx]) * wx[ci];
         end
         total += rowsum * wy[ri];
      end
      r = (total + (longint'(1) << 39)) >>> 40;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   function void note_input(bit kind, logic [4:0] idx, logic signed [15:0] dx,
                            logic signed [15:0] dy, logic [16:0] u, logic [16:0] v);
      longint gx;
      longint gy;
      longint wx[4];
      longint wy[4];
      if (kind == bwfs_pkg::KIND_WRITE) begin
         if (idx < 24) begin
            grid_x[idx] = dx;
            grid_y[idx] = dy;
         end
         return;
      end
      gx = (u > 65536 ? 65536 : u) * 5;
      gy = (v > 65536 ? 65536 : v) * 3;
      axis_weights(gx[15:0], wx);
      axis_weights(gy[15:0], wy);
      owed_x = {owed_x, blend(0, int'(gx >> 16), int'(gy >> 16), wx, wy)};
      owed_y = {owed_y, blend(1, int'(gx >> 16), int'(gy >> 16), wx, wy)};
   endfunction

   function void check_result(logic signed [15:0] ax, logic signed [15:0] ay);
      logic signed [15:0] ex;
      logic signed [15:0] ey;
      if (owed_x.size() == 0) begin
         $display("%0t unexpected result x=%0d y=%0d", $time, ax, ay);
         errors++;
         return;
      end
      ex = owed_x.pop_front();
      ey = owed_y.pop_front();
      if (ax !== ex) begin
         $display("%0t disp_x expected %0d actual %0d", $time, ex, ax);
         errors++;
      end
      if (ay !== ey) begin
         $display("%0t disp_y expected %0d actual %0d", $time, ey, ay);
         errors++;
      end
   endfunction
endclass

module tb_top;
   import bwfs_pkg::*;

   logic clock;
   logic reset;
   logic push;
   logic full;
   logic req_kind;
   logic [NODE_IDX_W-1:0] req_node_index;
   logic signed [DISP_W-1:0] req_node_dx;
   logic signed [DISP_W-1:0] req_node_dy;
   logic [COORD_W-1:0] req_coord_u;
   logic [COORD_W-1:0] req_coord_v;
   logic empty;
   logic pop;
   logic signed [DISP_W-1:0] rsp_disp_x;
   logic signed [DISP_W-1:0] rsp_disp_y;

   warp_scoreboard sb;
   bit calm;
   int unsigned cycles;

   bspline_warp_field_sampler u_top (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result side with random stall bursts
   initial begin
      int stall;
      pop = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (pop && !empty) sb.check_result(rsp_disp_x, rsp_disp_y);
         if (stall > 0) begin
            stall--;
            pop <= 0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(0, 17);
            pop <= 0;
         end else pop <= 1;
      end
   end

   task automatic send(bit kind, logic [4:0] idx, logic signed [15:0] dx,
                       logic signed [15:0] dy, logic [16:0] u, logic [16:0] v);
      push <= 1;
      req_kind <= kind;
      req_node_index <= idx;
      req_node_dx <= dx;
      req_node_dy <= dy;
      req_coord_u <= u;
      req_coord_v <= v;
      do @(posedge clock); while (full);
      sb.note_input(kind, idx, dx, dy, u, v);
      if (!calm && $urandom_range(0, 9) == 0) begin
         push <= 0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic send_random(bit kind);
      logic [16:0] u;
      logic [16:0] v;
      u = $urandom_range(0, 3) == 0 ? 17'($urandom) : 17'($urandom_range(0, 65536));
      v = $urandom_range(0, 3) == 0 ? 17'($urandom) : 17'($urandom_range(0, 65536));
      send(kind, $urandom_range(0, 9) == 0 ? 5'($urandom) : 5'($urandom_range(0, 23)),
           16'($urandom), 16'($urandom), u, v);
   endtask

   task automatic wait_drained();
      push <= 0;
      while (sb.owed_x.size() != 0) @(posedge clock);
   endtask

   initial begin
      sb = new();
      calm = 0;
      cycles = 0;
      reset = 1;
      push = 0;
      req_kind = 0;
      req_node_index = 0;
      req_node_dx = 0;
      req_node_dy = 0;
      req_coord_u = 0;
      req_coord_v = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send(KIND_SAMPLE, 0, 0, 0, 17'd32768, 17'd32768);
      send(KIND_WRITE, 0, 16'sh7fff, -16'sh8000, 0, 0);
      send(KIND_WRITE, 23, -16'sh8000, 16'sh7fff, 0, 0);
      send(KIND_WRITE, 31, 16'sh1234, 16'sh4321, 0, 0);
      send(KIND_WRITE, 24, 16'sh1111, 16'sh2222, 0, 0);
      send(KIND_SAMPLE, 31, 5, 5, 0, 0);
      send(KIND_SAMPLE, 0, 0, 0, 17'd65536, 17'd65536);
      send(KIND_SAMPLE, 0, 0, 0, 17'h1ffff, 17'h1ffff);
      send(KIND_SAMPLE, 0, 0, 0, 17'd65535, 17'd1);
      send(KIND_SAMPLE, 0, 0, 0, 17'd13107, 17'd21845);
      for (int i = 0; i < 24; i++) send(KIND_WRITE, 5'(i), 16'sh7fff, -16'sh8000, 0, 0);
      send(KIND_SAMPLE, 0, 0, 0, 17'd40000, 17'd30000);
      wait_drained();
      for (int i = 0; i < 850; i++) begin
         if (i == 700) begin
            wait_drained();
            calm = 1;
         end
         send_random($urandom_range(0, 2) != 0);
      end
      push <= 0;
      while (sb.owed_x.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.owed_x.size() == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule

// ----- files.f -----
rtl/bwfs_pkg.sv
rtl/bwfs_ram.sv
rtl/bwfs_front.sv
rtl/bwfs_back.sv
rtl/bspline_warp_field_sampler.sv
tb/tb_top.sv
